FILE: rtl/v3a_pkg.sv
// Shared types, constants and helper functions for the vector ALU.
package v3a_pkg;

  localparam int QW    = 32;            // Q16.16 word width
  localparam int FRAC  = 16;            // fraction bits
  localparam int VEC_N = 3;             // vector components
  localparam int NMUL  = 2 * VEC_N;     // multipliers in the product stage
  localparam int OPW   = QW + 1;        // multiplier operand width
  localparam int PRODW = 2 * OPW;       // product width
  localparam int PAIRW = PRODW + 1;     // difference of two products
  localparam int SUMW  = PAIRW + 2;     // sum of three pairs
  localparam int RADW  = 2 * QW;        // square root radicand width
  localparam int ROOTW = QW + 1;        // rounded root width
  localparam int NUMW  = QW + FRAC + 2; // divider numerator width
  localparam int DENW  = ROOTW + 1;     // divider denominator width

  localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [SUMW-1:0] HALF_LSB = SUMW'(1) <<< (FRAC-1);

  typedef enum logic [3:0] {
    FUNC_ADD   = 4'd0,
    FUNC_SUB   = 4'd1,
    FUNC_CROSS = 4'd2,
    FUNC_DOT   = 4'd3,
    FUNC_SCALE = 4'd4,
    FUNC_DIV   = 4'd5,
    FUNC_NORM  = 4'd6,
    FUNC_MAG   = 4'd7,
    FUNC_SQMAG = 4'd8,
    FUNC_DIST  = 4'd9
  } func_e;

  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_ZERO = 2'd1,
    ERR_SAT  = 2'd2
  } err_e;

  typedef logic signed [QW-1:0] word_t;

  // Everything an item carries past the product stages.
  typedef struct packed {
    logic [3:0]             func;
    logic [VEC_N-1:0][QW-1:0] r;
    logic [QW-1:0]          rs;
    logic                   sat;
    logic                   zero;
    logic [VEC_N-1:0][QW-1:0] a;
    logic [QW-1:0]          s;
  } side_t;

  localparam int SIDE_W = $bits(side_t);

  typedef struct packed {
    logic [QW-1:0] val;
    logic          sat;
  } satw_t;

  function automatic satw_t sat_word(input logic signed [SUMW-1:0] v);
    satw_t o;
    o.sat = 1'b1;
    if (v > SUMW'(QMAX)) begin
      o.val = QMAX;
    end else if (v < SUMW'(QMIN)) begin
      o.val = QMIN;
    end else begin
      o.val = v[QW-1:0];
      o.sat = 1'b0;
    end
    return o;
  endfunction

  // Round half up from Q32.32 to Q16.16.
  function automatic logic signed [SUMW-1:0] rnd_q(input logic signed [SUMW-1:0] v);
    return (v + HALF_LSB) >>> FRAC;
  endfunction

endpackage

FILE: rtl/v3a_front.sv
// Operand select, multipliers, product sums and rounding of the vector ALU.
module v3a_front import v3a_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [3:0]               func_i,
  input  logic [VEC_N-1:0][QW-1:0] a_i,
  input  logic [VEC_N-1:0][QW-1:0] b_i,
  input  logic [QW-1:0]            s_i,
  output logic                     valid_o,
  output logic [RADW-1:0]          rad_o,
  output side_t                    side_o
);

  localparam int TW = RADW - FRAC + 1;

  logic [5:0] v_q;

  // Stage 1: input register.
  logic [3:0]               f1_func_q;
  logic [VEC_N-1:0][QW-1:0] f1_a_q, f1_b_q;
  logic [QW-1:0]            f1_s_q;

  // Stage 2: operands and add/sub results.
  logic signed [OPW-1:0]    opl_d [NMUL];
  logic signed [OPW-1:0]    opr_d [NMUL];
  logic [VEC_N-1:0][QW-1:0] as_d;
  logic                     as_sat_d;
  logic [3:0]               f2_func_q;
  logic signed [OPW-1:0]    f2_opl_q [NMUL];
  logic signed [OPW-1:0]    f2_opr_q [NMUL];
  logic [VEC_N-1:0][QW-1:0] f2_as_q, f2_a_q;
  logic                     f2_as_sat_q;
  logic [QW-1:0]            f2_s_q;

  // Stage 3: products.
  logic [3:0]               f3_func_q;
  logic signed [PRODW-1:0]  f3_prod_q [NMUL];
  logic [VEC_N-1:0][QW-1:0] f3_as_q, f3_a_q;
  logic                     f3_as_sat_q;
  logic [QW-1:0]            f3_s_q;

  // Stage 4: product pairs.
  logic [3:0]               f4_func_q;
  logic signed [PAIRW-1:0]  f4_pair_q [VEC_N];
  logic [VEC_N-1:0][QW-1:0] f4_as_q, f4_a_q;
  logic                     f4_as_sat_q;
  logic [QW-1:0]            f4_s_q;

  // Stage 5: three-term sum and rounded vector components.
  logic signed [SUMW-1:0]   sum_d;
  logic [VEC_N-1:0][QW-1:0] rv_d;
  logic                     rv_sat_d;
  logic [3:0]               f5_func_q;
  logic signed [SUMW-1:0]   f5_sum_q;
  logic [VEC_N-1:0][QW-1:0] f5_rv_q, f5_as_q, f5_a_q;
  logic                     f5_rv_sat_q, f5_as_sat_q;
  logic [QW-1:0]            f5_s_q;

  // Stage 6: scalar results and the beat handed to the root pipeline.
  satw_t                    dot_w;
  logic [RADW-1:0]          sq;
  logic                     carry;
  logic [TW-1:0]            sqm;
  side_t                    side_d;
  side_t                    side_q;
  logic [RADW-1:0]          rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_comb begin
    logic signed [OPW-1:0] ea [VEC_N];
    logic signed [OPW-1:0] eb [VEC_N];
    logic signed [OPW-1:0] dif [VEC_N];
    logic signed [OPW-1:0] res;
    satw_t w;
    as_sat_d = 1'b0;
    for (int i = 0; i < VEC_N; i++) begin
      ea[i]  = $signed({f1_a_q[i][QW-1], f1_a_q[i]});
      eb[i]  = $signed({f1_b_q[i][QW-1], f1_b_q[i]});
      dif[i] = ea[i] - eb[i];
      res    = (f1_func_q == FUNC_ADD) ? ea[i] + eb[i] : dif[i];
      w      = sat_word(SUMW'(res));
      as_d[i]  = w.val;
      as_sat_d = as_sat_d | w.sat;
    end
    for (int k = 0; k < NMUL; k++) begin
      opl_d[k] = '0;
      opr_d[k] = '0;
    end
    unique case (f1_func_q)
      FUNC_CROSS: begin
        opl_d[0] = ea[1]; opr_d[0] = eb[2];
        opl_d[1] = eb[1]; opr_d[1] = ea[2];
        opl_d[2] = eb[0]; opr_d[2] = ea[2];
        opl_d[3] = ea[0]; opr_d[3] = eb[2];
        opl_d[4] = ea[0]; opr_d[4] = eb[1];
        opl_d[5] = eb[0]; opr_d[5] = ea[1];
      end
      FUNC_DOT: begin
        for (int i = 0; i < VEC_N; i++) begin
          opl_d[2*i] = ea[i]; opr_d[2*i] = eb[i];
        end
      end
      FUNC_SCALE: begin
        for (int i = 0; i < VEC_N; i++) begin
          opl_d[2*i] = ea[i]; opr_d[2*i] = $signed({f1_s_q[QW-1], f1_s_q});
        end
      end
      FUNC_NORM, FUNC_MAG, FUNC_SQMAG: begin
        for (int i = 0; i < VEC_N; i++) begin
          opl_d[2*i] = ea[i]; opr_d[2*i] = ea[i];
        end
      end
      FUNC_DIST: begin
        for (int i = 0; i < VEC_N; i++) begin
          opl_d[2*i] = dif[i]; opr_d[2*i] = dif[i];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    satw_t w;
    sum_d    = '0;
    rv_sat_d = 1'b0;
    for (int i = 0; i < VEC_N; i++) begin
      sum_d    = sum_d + SUMW'(f4_pair_q[i]);
      w        = sat_word(rnd_q(SUMW'(f4_pair_q[i])));
      rv_d[i]  = w.val;
      rv_sat_d = rv_sat_d | w.sat;
    end
  end

  always_comb begin
    dot_w = sat_word(rnd_q(f5_sum_q));
    sq    = f5_sum_q[RADW-1:0];
    carry = |f5_sum_q[SUMW-1:RADW];
    sqm   = {1'b0, sq[RADW-1:FRAC]} + TW'(sq[FRAC-1]);
    side_d      = '0;
    side_d.func = f5_func_q;
    side_d.a    = f5_a_q;
    side_d.s    = f5_s_q;
    unique case (f5_func_q)
      FUNC_ADD, FUNC_SUB: begin
        side_d.r   = f5_as_q;
        side_d.sat = f5_as_sat_q;
      end
      FUNC_CROSS, FUNC_SCALE: begin
        side_d.r   = f5_rv_q;
        side_d.sat = f5_rv_sat_q;
      end
      FUNC_DOT: begin
        side_d.rs  = dot_w.val;
        side_d.sat = dot_w.sat;
      end
      FUNC_SQMAG: begin
        if (sqm > TW'(QMAX)) begin
          side_d.rs  = QMAX;
          side_d.sat = 1'b1;
        end else begin
          side_d.rs  = sqm[QW-1:0];
        end
      end
      // A carry out of 64 bits already means a saturated magnitude.
      FUNC_MAG, FUNC_DIST: begin
        side_d.sat = carry;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_func_q <= func_i;
      f1_a_q    <= a_i;
      f1_b_q    <= b_i;
      f1_s_q    <= s_i;

      f2_func_q   <= f1_func_q;
      f2_as_q     <= as_d;
      f2_as_sat_q <= as_sat_d;
      f2_a_q      <= f1_a_q;
      f2_s_q      <= f1_s_q;
      for (int k = 0; k < NMUL; k++) begin
        f2_opl_q[k] <= opl_d[k];
        f2_opr_q[k] <= opr_d[k];
      end

      f3_func_q   <= f2_func_q;
      f3_as_q     <= f2_as_q;
      f3_as_sat_q <= f2_as_sat_q;
      f3_a_q      <= f2_a_q;
      f3_s_q      <= f2_s_q;
      for (int k = 0; k < NMUL; k++) begin
        f3_prod_q[k] <= f2_opl_q[k] * f2_opr_q[k];
      end

      f4_func_q   <= f3_func_q;
      f4_as_q     <= f3_as_q;
      f4_as_sat_q <= f3_as_sat_q;
      f4_a_q      <= f3_a_q;
      f4_s_q      <= f3_s_q;
      for (int i = 0; i < VEC_N; i++) begin
        f4_pair_q[i] <= PAIRW'(f3_prod_q[2*i]) - PAIRW'(f3_prod_q[2*i+1]);
      end

      f5_func_q   <= f4_func_q;
      f5_sum_q    <= sum_d;
      f5_rv_q     <= rv_d;
      f5_rv_sat_q <= rv_sat_d;
      f5_as_q     <= f4_as_q;
      f5_as_sat_q <= f4_as_sat_q;
      f5_a_q      <= f4_a_q;
      f5_s_q      <= f4_s_q;

      side_q <= side_d;
      rad_q  <= sq;
    end
  end

  assign valid_o = v_q[5];
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

FILE: rtl/v3a_sqrt.sv
// Pipelined rounded integer square root, one result bit per stage.
module v3a_sqrt import v3a_pkg::*; #(
  parameter int SideW = SIDE_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [RADW-1:0]  rad_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [ROOTW-1:0] root_o,
  output logic [SideW-1:0] side_o
);

  localparam int Steps = RADW / 2;

  logic [Steps:0]     v_q;
  logic               out_v_q;
  logic [RADW-1:0]    x_q   [Steps+1];
  logic [RADW-1:0]    res_q [Steps+1];
  logic [SideW-1:0]   side_q [Steps+1];
  logic [RADW-1:0]    x_d   [Steps];
  logic [RADW-1:0]    res_d [Steps];
  logic [ROOTW-1:0]   root_q;
  logic [SideW-1:0]   out_side_q;

  always_comb begin
    logic [RADW-1:0] step_bit;
    logic [RADW:0]   trial;
    for (int k = 0; k < Steps; k++) begin
      step_bit = RADW'(1) << (RADW - 2 - 2 * k);
      trial    = {1'b0, res_q[k]} + {1'b0, step_bit};
      if ({1'b0, x_q[k]} >= trial) begin
        x_d[k]   = x_q[k] - trial[RADW-1:0];
        res_d[k] = (res_q[k] >> 1) + step_bit;
      end else begin
        x_d[k]   = x_q[k];
        res_d[k] = res_q[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      v_q     <= {v_q[Steps-1:0], valid_i};
      out_v_q <= v_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= rad_i;
      res_q[0]  <= '0;
      side_q[0] <= side_i;
      for (int k = 0; k < Steps; k++) begin
        x_q[k+1]    <= x_d[k];
        res_q[k+1]  <= res_d[k];
        side_q[k+1] <= side_q[k];
      end
      // Round to nearest: bump the root when the remainder exceeds it.
      root_q     <= res_q[Steps][ROOTW-1:0] + ROOTW'(x_q[Steps] > res_q[Steps]);
      out_side_q <= side_q[Steps];
    end
  end

  assign valid_o = out_v_q;
  assign root_o  = root_q;
  assign side_o  = out_side_q;

endmodule

FILE: rtl/v3a_div.sv
// Pipelined three-lane restoring divider with sign handling and saturation.
module v3a_div import v3a_pkg::*; #(
  parameter int SideW = SIDE_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [VEC_N-1:0][NUMW-1:0] num_i,
  input  logic [DENW-1:0]            den_i,
  input  logic [VEC_N-1:0]           neg_i,
  input  logic [SideW-1:0]           side_i,
  output logic                       valid_o,
  output logic [VEC_N-1:0][QW-1:0]   quo_o,
  output logic [VEC_N-1:0]           sat_o,
  output logic [SideW-1:0]           side_o
);

  localparam int Steps = QW;
  localparam int CW    = DENW + QW;
  localparam logic [QW-1:0] NegLim = {1'b1, {(QW-1){1'b0}}};

  logic                       in_v_q;
  logic [VEC_N-1:0][NUMW-1:0] in_num_q;
  logic [DENW-1:0]            in_den_q;
  logic [VEC_N-1:0]           in_neg_q;
  logic [SideW-1:0]           in_side_q;

  logic [Steps:0]             v_q;
  logic [VEC_N-1:0][NUMW-1:0] rem_q  [Steps+1];
  logic [VEC_N-1:0][QW-1:0]   quo_q  [Steps+1];
  logic [VEC_N-1:0]           ovf_q  [Steps+1];
  logic [VEC_N-1:0]           neg_q  [Steps+1];
  logic [DENW-1:0]            den_q  [Steps+1];
  logic [SideW-1:0]           side_q [Steps+1];

  logic [VEC_N-1:0]           ovf_d;
  logic [VEC_N-1:0][NUMW-1:0] rem_d [Steps];
  logic [VEC_N-1:0][QW-1:0]   quo_d [Steps];
  logic [VEC_N-1:0][QW-1:0]   res_d;
  logic [VEC_N-1:0]           sat_d;

  logic                       out_v_q;
  logic [VEC_N-1:0][QW-1:0]   out_quo_q;
  logic [VEC_N-1:0]           out_sat_q;
  logic [SideW-1:0]           out_side_q;

  // A quotient of 2^32 or more saturates either way, so 32 bits are enough.
  always_comb begin
    for (int i = 0; i < VEC_N; i++) begin
      ovf_d[i] = CW'(in_num_q[i]) >= {in_den_q, {QW{1'b0}}};
    end
  end

  always_comb begin
    logic [CW-1:0] dsh;
    for (int k = 0; k < Steps; k++) begin
      dsh = CW'(den_q[k]) << (QW - 1 - k);
      for (int i = 0; i < VEC_N; i++) begin
        if (!ovf_q[k][i] && (CW'(rem_q[k][i]) >= dsh)) begin
          rem_d[k][i] = rem_q[k][i] - dsh[NUMW-1:0];
          quo_d[k][i] = quo_q[k][i] | (QW'(1) << (QW - 1 - k));
        end else begin
          rem_d[k][i] = rem_q[k][i];
          quo_d[k][i] = quo_q[k][i];
        end
      end
    end
  end

  always_comb begin
    logic [QW-1:0]       q;
    logic signed [QW:0]  nq;
    for (int i = 0; i < VEC_N; i++) begin
      q  = quo_q[Steps][i];
      nq = -$signed({1'b0, q});
      sat_d[i] = 1'b1;
      if (ovf_q[Steps][i]) begin
        res_d[i] = neg_q[Steps][i] ? QMIN : QMAX;
      end else if (!neg_q[Steps][i]) begin
        if (q > QMAX) begin
          res_d[i] = QMAX;
        end else begin
          res_d[i] = q;
          sat_d[i] = 1'b0;
        end
      end else if (q > NegLim) begin
        res_d[i] = QMIN;
      end else begin
        res_d[i] = nq[QW-1:0];
        sat_d[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      in_v_q  <= valid_i;
      v_q     <= {v_q[Steps-1:0], in_v_q};
      out_v_q <= v_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in_num_q  <= num_i;
      in_den_q  <= den_i;
      in_neg_q  <= neg_i;
      in_side_q <= side_i;

      rem_q[0]  <= in_num_q;
      quo_q[0]  <= '0;
      ovf_q[0]  <= ovf_d;
      neg_q[0]  <= in_neg_q;
      den_q[0]  <= in_den_q;
      side_q[0] <= in_side_q;
      for (int k = 0; k < Steps; k++) begin
        rem_q[k+1]  <= rem_d[k];
        quo_q[k+1]  <= quo_d[k];
        ovf_q[k+1]  <= ovf_q[k];
        neg_q[k+1]  <= neg_q[k];
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
      end

      out_quo_q  <= res_d;
      out_sat_q  <= sat_d;
      out_side_q <= side_q[Steps];
    end
  end

  assign valid_o = out_v_q;
  assign quo_o   = out_quo_q;
  assign sat_o   = out_sat_q;
  assign side_o  = out_side_q;

endmodule

FILE: rtl/vector3_alu.sv
// Top level of the pipelined three-component Q16.16 vector ALU.
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds when the output register is full and not taken.
// Reset clears only the valid bits; the pipeline is ready right after reset.
module vector3_alu import v3a_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [3:0]        func_i,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] a_z_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] b_z_i,
  input  logic signed [31:0] scalar_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [31:0] r_x_o,
  output logic signed [31:0] r_y_o,
  output logic signed [31:0] r_z_o,
  output logic signed [31:0] r_scalar_o,
  output logic [1:0]        error_o
);

  logic                       en;
  logic [VEC_N-1:0][QW-1:0]   a_vec, b_vec;

  logic                       fr_valid;
  logic [RADW-1:0]            fr_rad;
  side_t                      fr_side;

  logic                       sq_valid;
  logic [ROOTW-1:0]           sq_root;
  logic [SIDE_W-1:0]          sq_side_raw;
  side_t                      sq_side;

  side_t                      mid_side_d;
  logic [VEC_N-1:0][NUMW-1:0] mid_num_d;
  logic [DENW-1:0]            mid_den_d;
  logic [VEC_N-1:0]           mid_neg_d;
  logic                       mid_v_q;
  side_t                      mid_side_q;
  logic [VEC_N-1:0][NUMW-1:0] mid_num_q;
  logic [DENW-1:0]            mid_den_q;
  logic [VEC_N-1:0]           mid_neg_q;

  logic                       dv_valid;
  logic [VEC_N-1:0][QW-1:0]   dv_quo;
  logic [VEC_N-1:0]           dv_sat;
  logic [SIDE_W-1:0]          dv_side_raw;
  side_t                      dv_side;

  logic [VEC_N-1:0][QW-1:0]   r_d;
  logic [QW-1:0]              rs_d;
  err_e                       err_d;
  logic                       out_v_q;
  logic [VEC_N-1:0][QW-1:0]   r_q;
  logic [QW-1:0]              rs_q;
  err_e                       err_q;

  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;
  assign a_vec      = {a_z_i, a_y_i, a_x_i};
  assign b_vec      = {b_z_i, b_y_i, b_x_i};

  v3a_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .func_i  (func_i),
    .a_i     (a_vec),
    .b_i     (b_vec),
    .s_i     (scalar_i),
    .valid_o (fr_valid),
    .rad_o   (fr_rad),
    .side_o  (fr_side)
  );

  v3a_sqrt #(.SideW(SIDE_W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .rad_i   (fr_rad),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side_raw)
  );

  assign sq_side = sq_side_raw;

  // Pick the divisor, flag zero divisors and finish magnitude results.
  always_comb begin
    logic signed [QW:0] s_ext;
    logic signed [QW:0] a_ext;
    logic [ROOTW-1:0]   abs_s;
    logic [ROOTW-1:0]   abs_a;
    logic [ROOTW-1:0]   den;
    logic               is_div;
    mid_side_d = sq_side;
    is_div = (sq_side.func == FUNC_DIV);
    s_ext  = $signed({sq_side.s[QW-1], sq_side.s});
    abs_s  = s_ext[QW] ? -s_ext : s_ext;
    den    = is_div ? abs_s : sq_root;
    mid_side_d.zero = (is_div || (sq_side.func == FUNC_NORM)) && (den == '0);
    if ((sq_side.func == FUNC_MAG) || (sq_side.func == FUNC_DIST)) begin
      if (sq_side.sat) begin
        mid_side_d.rs = QMAX;
      end else if (sq_root > ROOTW'(QMAX)) begin
        mid_side_d.rs  = QMAX;
        mid_side_d.sat = 1'b1;
      end else begin
        mid_side_d.rs = sq_root[QW-1:0];
      end
    end
    for (int i = 0; i < VEC_N; i++) begin
      a_ext = $signed({sq_side.a[i][QW-1], sq_side.a[i]});
      abs_a = a_ext[QW] ? -a_ext : a_ext;
      // Numerator 2*|a|*2^16 + d over 2*d rounds the quotient half up.
      mid_num_d[i] = NUMW'({abs_a[QW-1:0], {(FRAC+1){1'b0}}}) + NUMW'(den);
      mid_neg_d[i] = sq_side.a[i][QW-1] ^ (is_div && sq_side.s[QW-1]);
    end
    mid_den_d = {den, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      mid_v_q <= sq_valid;
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mid_side_q <= mid_side_d;
      mid_num_q  <= mid_num_d;
      mid_den_q  <= mid_den_d;
      mid_neg_q  <= mid_neg_d;
      r_q        <= r_d;
      rs_q       <= rs_d;
      err_q      <= err_d;
    end
  end

  v3a_div #(.SideW(SIDE_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mid_v_q),
    .num_i   (mid_num_q),
    .den_i   (mid_den_q),
    .neg_i   (mid_neg_q),
    .side_i  (mid_side_q),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .sat_o   (dv_sat),
    .side_o  (dv_side_raw)
  );

  assign dv_side = dv_side_raw;

  always_comb begin
    logic sat;
    r_d  = dv_side.r;
    rs_d = dv_side.rs;
    sat  = dv_side.sat;
    if ((dv_side.func == FUNC_DIV) || (dv_side.func == FUNC_NORM)) begin
      if (dv_side.zero) begin
        r_d = '0;
        sat = 1'b0;
      end else begin
        r_d = dv_quo;
        sat = |dv_sat;
      end
    end
    if (dv_side.zero) begin
      err_d = ERR_ZERO;
    end else if (sat) begin
      err_d = ERR_SAT;
    end else begin
      err_d = ERR_OK;
    end
  end

  assign out_valid_o = out_v_q;
  assign r_x_o       = r_q[0];
  assign r_y_o       = r_q[1];
  assign r_z_o       = r_q[2];
  assign r_scalar_o  = rs_q;
  assign error_o     = err_q;

endmodule
